/* rtl/core/jdsm_pkg.sv */
// Shared constants, register indexes and stage control types of the joystick mapper.
`timescale 1ns / 1ps
package jdsm_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int DEAD_BITS       = 9;
  localparam int OUT_BITS        = 7;
  localparam int ANG_BITS        = 8;
  localparam int QUO_BITS        = 8;
  localparam int OUT_SPAN        = 45;
  localparam int NUM_AXES        = 2;
  localparam int CFG_IDX_BITS    = 3;

  localparam int AX_RUDDER = 0;
  localparam int AX_SAIL   = 1;

  localparam logic signed [ANG_BITS-1:0] AXIS_MIN [NUM_AXES] = '{-8'sd45, 8'sd0};
  localparam logic signed [ANG_BITS-1:0] AXIS_MID [NUM_AXES] = '{8'sd0, 8'sd45};
  localparam logic signed [ANG_BITS-1:0] AXIS_MAX [NUM_AXES] = '{8'sd45, 8'sd90};

  localparam int RST_LOW  = 0;
  localparam int RST_HIGH = 1023;
  localparam int RST_MID  = 512;
  localparam int RST_DEAD = 20;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_LOW     = 3'd0,
    REG_X_HIGH    = 3'd1,
    REG_X_MID     = 3'd2,
    REG_Y_LOW     = 3'd3,
    REG_Y_HIGH    = 3'd4,
    REG_Y_MID     = 3'd5,
    REG_DEAD_BAND = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                       forced;
    logic                       neg;
    logic                       ovf;
    logic signed [ANG_BITS-1:0] force_val;
    logic signed [ANG_BITS-1:0] base;
  } axis_ctl_t;

endpackage

/* rtl/core/jdsm_front.sv */
// Front stages: dead-zone branch choice, then scaled numerator, divisor and sign per axis.
`timescale 1ns / 1ps
module jdsm_front import jdsm_pkg::*; #(
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CW   = (SAMPLE_BITS > DEAD_BITS) ? SAMPLE_BITS : DEAD_BITS,
  localparam int EW   = CW + 2,
  localparam int NMAG = CW + 1,
  localparam int MW   = NMAG + 6,
  localparam int DW   = NMAG + 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_vld,
  output logic                   rdy,
  input  logic [SAMPLE_BITS-1:0] smp   [NUM_AXES],
  input  logic [SAMPLE_BITS-1:0] lo    [NUM_AXES],
  input  logic [SAMPLE_BITS-1:0] hi    [NUM_AXES],
  input  logic [SAMPLE_BITS-1:0] mid   [NUM_AXES],
  input  logic [DEAD_BITS-1:0]   db,
  input  logic                   nxt_rdy,
  output logic                   o_vld,
  output logic [DW-1:0]          o_rem [NUM_AXES],
  output logic [NMAG-1:0]        o_dvs [NUM_AXES],
  output logic [QUO_BITS-1:0]    o_quo [NUM_AXES],
  output axis_ctl_t              o_ctl [NUM_AXES]
);

  logic                 a_vld_r;
  logic                 a_rdy;
  logic signed [EW-1:0] num_r    [NUM_AXES];
  logic signed [EW-1:0] num_nxt  [NUM_AXES];
  logic signed [EW-1:0] span_r   [NUM_AXES];
  logic signed [EW-1:0] span_nxt [NUM_AXES];
  logic                 low_r    [NUM_AXES];
  logic                 low_nxt  [NUM_AXES];
  logic                 high_r   [NUM_AXES];
  logic                 high_nxt [NUM_AXES];

  logic                 b_vld_r;
  logic                 b_rdy;
  logic [DW-1:0]        rem_r    [NUM_AXES];
  logic [DW-1:0]        rem_nxt  [NUM_AXES];
  logic [NMAG-1:0]      dvs_r    [NUM_AXES];
  logic [NMAG-1:0]      dvs_nxt  [NUM_AXES];
  axis_ctl_t            ctl_r    [NUM_AXES];
  axis_ctl_t            ctl_nxt  [NUM_AXES];

  assign b_rdy = !b_vld_r || nxt_rdy;
  assign a_rdy = !a_vld_r || b_rdy;
  assign rdy   = a_rdy;

  always_comb begin
    logic signed [EW-1:0] s_e;
    logic signed [EW-1:0] lo_e;
    logic signed [EW-1:0] hi_e;
    logic signed [EW-1:0] near_e;
    logic signed [EW-1:0] far_e;
    for (int a = 0; a < NUM_AXES; a++) begin
      s_e         = EW'(smp[a]);
      lo_e        = EW'(lo[a]);
      hi_e        = EW'(hi[a]);
      near_e      = EW'(mid[a]) - EW'(db);
      far_e       = EW'(mid[a]) + EW'(db);
      low_nxt[a]  = s_e < near_e;
      high_nxt[a] = s_e > far_e;
      num_nxt[a]  = low_nxt[a] ? (s_e - lo_e) : (s_e - far_e);
      span_nxt[a] = low_nxt[a] ? (near_e - lo_e) : (hi_e - far_e);
    end
  end

  always_comb begin
    logic            in_zone;
    logic [NMAG-1:0] mag_n;
    logic [MW-1:0]   prod;
    for (int a = 0; a < NUM_AXES; a++) begin
      in_zone = !(low_r[a] || high_r[a]);
      mag_n   = num_r[a][EW-1] ? NMAG'(-num_r[a]) : NMAG'(num_r[a]);
      dvs_nxt[a] = span_r[a][EW-1] ? NMAG'(-span_r[a]) : NMAG'(span_r[a]);
      prod    = MW'(mag_n) * MW'(OUT_SPAN);
      rem_nxt[a] = DW'(prod);
      ctl_nxt[a].forced    = in_zone || (span_r[a] == '0);
      ctl_nxt[a].neg       = num_r[a][EW-1] ^ span_r[a][EW-1];
      ctl_nxt[a].ovf       = DW'(prod) >= (DW'(dvs_nxt[a]) << QUO_BITS);
      ctl_nxt[a].force_val = in_zone ? AXIS_MID[a] : (low_r[a] ? AXIS_MIN[a] : AXIS_MAX[a]);
      ctl_nxt[a].base      = low_r[a] ? AXIS_MIN[a] : AXIS_MID[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_r <= i_vld;
      end
      if (b_rdy) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      num_r  <= num_nxt;
      span_r <= span_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
    if (b_rdy) begin
      rem_r <= rem_nxt;
      dvs_r <= dvs_nxt;
      ctl_r <= ctl_nxt;
    end
  end

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      o_quo[a] = '0;
    end
  end

  assign o_vld = b_vld_r;
  assign o_rem = rem_r;
  assign o_dvs = dvs_r;
  assign o_ctl = ctl_r;

endmodule

/* rtl/core/jdsm_div_cell.sv */
// One restoring division cell: settles one quotient bit per axis and hands on the remainder.
`timescale 1ns / 1ps
module jdsm_div_cell import jdsm_pkg::*; #(
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter  int SHIFT       = 0,
  localparam int CW   = (SAMPLE_BITS > DEAD_BITS) ? SAMPLE_BITS : DEAD_BITS,
  localparam int NMAG = CW + 1,
  localparam int DW   = NMAG + 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_vld,
  output logic                rdy,
  input  logic [DW-1:0]       i_rem [NUM_AXES],
  input  logic [NMAG-1:0]     i_dvs [NUM_AXES],
  input  logic [QUO_BITS-1:0] i_quo [NUM_AXES],
  input  axis_ctl_t           i_ctl [NUM_AXES],
  input  logic                nxt_rdy,
  output logic                o_vld,
  output logic [DW-1:0]       o_rem [NUM_AXES],
  output logic [NMAG-1:0]     o_dvs [NUM_AXES],
  output logic [QUO_BITS-1:0] o_quo [NUM_AXES],
  output axis_ctl_t           o_ctl [NUM_AXES]
);

  logic                vld_r;
  logic [DW-1:0]       rem_r   [NUM_AXES];
  logic [DW-1:0]       rem_nxt [NUM_AXES];
  logic [NMAG-1:0]     dvs_r   [NUM_AXES];
  logic [QUO_BITS-1:0] quo_r   [NUM_AXES];
  logic [QUO_BITS-1:0] quo_nxt [NUM_AXES];
  axis_ctl_t           ctl_r   [NUM_AXES];

  assign rdy = !vld_r || nxt_rdy;

  always_comb begin
    logic [DW-1:0] trial;
    logic          ge;
    for (int a = 0; a < NUM_AXES; a++) begin
      trial      = DW'(i_dvs[a]) << SHIFT;
      ge         = i_rem[a] >= trial;
      rem_nxt[a] = ge ? (i_rem[a] - trial) : i_rem[a];
      quo_nxt[a] = i_quo[a];
      quo_nxt[a][SHIFT] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      rem_r <= rem_nxt;
      dvs_r <= i_dvs;
      quo_r <= quo_nxt;
      ctl_r <= i_ctl;
    end
  end

  assign o_vld = vld_r;
  assign o_rem = rem_r;
  assign o_dvs = dvs_r;
  assign o_quo = quo_r;
  assign o_ctl = ctl_r;

endmodule

/* rtl/core/jdsm_back.sv */
// Output stage: signs the quotient, adds the branch base, clamps and holds the result request.
`timescale 1ns / 1ps
module jdsm_back import jdsm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       i_vld,
  output logic                       rdy,
  input  logic [QUO_BITS-1:0]        i_quo [NUM_AXES],
  input  axis_ctl_t                  i_ctl [NUM_AXES],
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [OUT_BITS-1:0] out_rudder_angle,
  output logic        [OUT_BITS-1:0] out_sail_angle
);

  localparam int VW = QUO_BITS + 2;

  logic                vld_r;
  logic [OUT_BITS-1:0] res_r   [NUM_AXES];
  logic [OUT_BITS-1:0] res_nxt [NUM_AXES];

  assign rdy = !vld_r || !out_stall;

  always_comb begin
    logic [QUO_BITS-1:0]  q;
    logic signed [VW-1:0] qs;
    logic signed [VW-1:0] v;
    for (int a = 0; a < NUM_AXES; a++) begin
      q  = i_ctl[a].ovf ? {QUO_BITS{1'b1}} : i_quo[a];
      qs = signed'(VW'(q));
      v  = VW'(i_ctl[a].base) + (i_ctl[a].neg ? -qs : qs);
      if (i_ctl[a].forced) begin
        v = VW'(i_ctl[a].force_val);
      end else if (v < VW'(AXIS_MIN[a])) begin
        v = VW'(AXIS_MIN[a]);
      end else if (v > VW'(AXIS_MAX[a])) begin
        v = VW'(AXIS_MAX[a]);
      end
      res_nxt[a] = v[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= i_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = vld_r;
  assign out_rudder_angle = signed'(res_r[AX_RUDDER]);
  assign out_sail_angle   = res_r[AX_SAIL];

endmodule

/* rtl/core/joystick_deadzone_split_mapper.sv */
// Top level of the joystick dead-zone mapper: configuration registers and the cell chain.
`timescale 1ns / 1ps
// The block takes one X/Y stick sample pair per clock when the output side does not stall
// and returns one rudder and one sail command per pair: two front stages pick the
// dead-zone branch and form the scaled numerator and divisor, a row of eight restoring
// division cells settles one quotient bit each, and an output register signs, offsets and
// clamps the result. Each stage holds its request only until its neighbor frees it, so
// the input keeps being taken while a finished result waits, if the row has a gap. The user
// writes calibration and dead band via cfg port while no request is in flight; unenforced.
module joystick_deadzone_split_mapper import jdsm_pkg::*; #(
  parameter  int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CW   = (SAMPLE_BITS > DEAD_BITS) ? SAMPLE_BITS : DEAD_BITS,
  localparam int NMAG = CW + 1,
  localparam int DW   = NMAG + 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CW-1:0]              cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     in_sample_x,
  input  logic [SAMPLE_BITS-1:0]     in_sample_y,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [OUT_BITS-1:0] out_rudder_angle,
  output logic        [OUT_BITS-1:0] out_sail_angle
);

  localparam int NST = QUO_BITS + 1;

  logic [SAMPLE_BITS-1:0] lo_r  [NUM_AXES];
  logic [SAMPLE_BITS-1:0] hi_r  [NUM_AXES];
  logic [SAMPLE_BITS-1:0] mid_r [NUM_AXES];
  logic [DEAD_BITS-1:0]   db_r;
  logic [SAMPLE_BITS-1:0] smp   [NUM_AXES];

  logic                   front_rdy;
  logic                   st_vld [NST];
  logic                   st_rdy [NST];
  logic [DW-1:0]          st_rem [NST][NUM_AXES];
  logic [NMAG-1:0]        st_dvs [NST][NUM_AXES];
  logic [QUO_BITS-1:0]    st_quo [NST][NUM_AXES];
  axis_ctl_t              st_ctl [NST][NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r[AX_RUDDER]  <= SAMPLE_BITS'(RST_LOW);
      hi_r[AX_RUDDER]  <= SAMPLE_BITS'(RST_HIGH);
      mid_r[AX_RUDDER] <= SAMPLE_BITS'(RST_MID);
      lo_r[AX_SAIL]    <= SAMPLE_BITS'(RST_LOW);
      hi_r[AX_SAIL]    <= SAMPLE_BITS'(RST_HIGH);
      mid_r[AX_SAIL]   <= SAMPLE_BITS'(RST_MID);
      db_r             <= DEAD_BITS'(RST_DEAD);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_X_LOW:     lo_r[AX_RUDDER]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_X_HIGH:    hi_r[AX_RUDDER]  <= cfg_data[SAMPLE_BITS-1:0];
        REG_X_MID:     mid_r[AX_RUDDER] <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_LOW:     lo_r[AX_SAIL]    <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_HIGH:    hi_r[AX_SAIL]    <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_MID:     mid_r[AX_SAIL]   <= cfg_data[SAMPLE_BITS-1:0];
        REG_DEAD_BAND: db_r             <= cfg_data[DEAD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign smp[AX_RUDDER] = in_sample_x;
  assign smp[AX_SAIL]   = in_sample_y;
  assign in_stall       = !front_rdy;

  jdsm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_vld   (in_valid),
    .rdy     (front_rdy),
    .smp     (smp),
    .lo      (lo_r),
    .hi      (hi_r),
    .mid     (mid_r),
    .db      (db_r),
    .nxt_rdy (st_rdy[0]),
    .o_vld   (st_vld[0]),
    .o_rem   (st_rem[0]),
    .o_dvs   (st_dvs[0]),
    .o_quo   (st_quo[0]),
    .o_ctl   (st_ctl[0])
  );

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_cell
    jdsm_div_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SHIFT       (QUO_BITS - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_vld   (st_vld[j]),
      .rdy     (st_rdy[j]),
      .i_rem   (st_rem[j]),
      .i_dvs   (st_dvs[j]),
      .i_quo   (st_quo[j]),
      .i_ctl   (st_ctl[j]),
      .nxt_rdy (st_rdy[j+1]),
      .o_vld   (st_vld[j+1]),
      .o_rem   (st_rem[j+1]),
      .o_dvs   (st_dvs[j+1]),
      .o_quo   (st_quo[j+1]),
      .o_ctl   (st_ctl[j+1])
    );
  end

  jdsm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .i_vld            (st_vld[NST-1]),
    .rdy              (st_rdy[NST-1]),
    .i_quo            (st_quo[NST-1]),
    .i_ctl            (st_ctl[NST-1]),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_rudder_angle (out_rudder_angle),
    .out_sail_angle   (out_sail_angle)
  );

  a_rudder_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ANG_BITS'(out_rudder_angle) >= AXIS_MIN[AX_RUDDER]) &&
                  (ANG_BITS'(out_rudder_angle) <= AXIS_MAX[AX_RUDDER]))
    else $error("rudder command outside its clamp range");

  a_sail_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (signed'(ANG_BITS'(out_sail_angle)) <= AXIS_MAX[AX_SAIL]))
    else $error("sail command outside its clamp range");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input refused while the output register is empty");

  a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
    (st_vld[NST-1] && !st_ctl[NST-1][AX_RUDDER].forced && !st_ctl[NST-1][AX_RUDDER].ovf)
      |-> (st_rem[NST-1][AX_RUDDER] < DW'(st_dvs[NST-1][AX_RUDDER])))
    else $error("rudder division left a remainder not below the divisor");

  a_rem_y: assert property (@(posedge clk) disable iff (!rst_n)
    (st_vld[NST-1] && !st_ctl[NST-1][AX_SAIL].forced && !st_ctl[NST-1][AX_SAIL].ovf)
      |-> (st_rem[NST-1][AX_SAIL] < DW'(st_dvs[NST-1][AX_SAIL])))
    else $error("sail division left a remainder not below the divisor");

endmodule
